>>> hw/rtl/rc4_stream_cipher_defines.svh
// ----------------------------------------------------------------------------
// RC4 stream cipher assertion macros
// Concurrent check helpers sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_DEFINES_SVH
`define RC4_STREAM_CIPHER_DEFINES_SVH

`ifndef SYNTHESIS
`define RC4_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rc4 check failed");
`define RC4_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rc4 check failed");
`else
`define RC4_ASSERT_IMP(lbl, ante, cons)
`define RC4_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> hw/rtl/rc4_pkg.sv
// ----------------------------------------------------------------------------
// RC4 stream cipher package
// Shared constants and types for the permutation store and sequencer.
// ----------------------------------------------------------------------------
package rc4_pkg;

    localparam int KEY_BYTES   = 64;
    localparam int KEY_WORDS   = 8;
    localparam int KEY_WORD_W  = 64;
    localparam int KEY_IDX_W   = 6;
    localparam int KEY_WSEL_W  = 3;
    localparam int PERM_DEPTH  = 256;
    localparam int PERM_AW     = 8;
    localparam int BYTE_W      = 8;

    typedef logic [KEY_WORDS-1:0][7:0][BYTE_W-1:0] key_t;

    typedef struct packed {
        logic               we;
        logic [PERM_AW-1:0] waddr;
        logic [BYTE_W-1:0]  wdata;
        logic [PERM_AW-1:0] raddr;
    } mem_req_t;

endpackage

>>> hw/rtl/rc4_perm_ram.sv
// ----------------------------------------------------------------------------
// RC4 permutation store
// 256 x 8 memory, one write and one registered read per cycle, read-first.
// ----------------------------------------------------------------------------
module rc4_perm_ram
(
    input  logic                        clk,
    input  rc4_pkg::mem_req_t           req,
    output logic [rc4_pkg::BYTE_W-1:0]  rdata
);

    logic [rc4_pkg::BYTE_W-1:0] mem [0:rc4_pkg::PERM_DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

>>> hw/rtl/rc4_seq.sv
// ----------------------------------------------------------------------------
// RC4 sequencer
// Drives key scheduling and keystream steps through one shared byte adder.
// ----------------------------------------------------------------------------
module rc4_seq
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [rc4_pkg::BYTE_W-1:0]  in_data,
    input  logic                        in_start,
    input  rc4_pkg::key_t               key,
    output rc4_pkg::mem_req_t           mem_req,
    input  logic [rc4_pkg::BYTE_W-1:0]  mem_rdata,
    output logic                        res_valid,
    input  logic                        res_ready,
    output logic [rc4_pkg::BYTE_W-1:0]  res_byte
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_INIT = 3'd1;
    localparam logic [2:0] ST_MIX  = 3'd2;
    localparam logic [2:0] ST_SWAP = 3'd3;
    localparam logic [2:0] ST_PJ   = 3'd4;
    localparam logic [2:0] ST_PWR  = 3'd5;
    localparam logic [2:0] ST_PKS  = 3'd6;

    localparam logic [rc4_pkg::PERM_AW-1:0]   LAST_N   = rc4_pkg::PERM_AW'(rc4_pkg::PERM_DEPTH - 1);
    localparam logic [rc4_pkg::KEY_IDX_W-1:0] LAST_KEY = rc4_pkg::KEY_IDX_W'(rc4_pkg::KEY_BYTES - 1);

    logic [2:0]                     state_reg, state_next;
    logic [rc4_pkg::PERM_AW-1:0]    n_reg, n_next;
    logic [rc4_pkg::KEY_IDX_W-1:0]  kidx_reg, kidx_next;
    logic [rc4_pkg::BYTE_W-1:0]     i_reg, i_next;
    logic [rc4_pkg::BYTE_W-1:0]     j_reg, j_next;
    logic                           keyed_reg, keyed_next;
    logic [rc4_pkg::BYTE_W-1:0]     si_reg, si_next;
    logic [rc4_pkg::BYTE_W-1:0]     sj_reg, sj_next;
    logic [rc4_pkg::PERM_AW-1:0]    t_reg, t_next;
    logic                           byp_reg, byp_next;
    logic [rc4_pkg::BYTE_W-1:0]     data_reg, data_next;

    logic [rc4_pkg::BYTE_W-1:0]     add_a, add_b, add_c, sum;
    logic [rc4_pkg::BYTE_W-1:0]     key_byte;

    assign key_byte = key[kidx_reg[rc4_pkg::KEY_IDX_W-1 -: rc4_pkg::KEY_WSEL_W]]
                         [kidx_reg[2:0]];

    // shared byte adder
    assign sum = add_a + add_b + add_c;

    always_comb
    begin
        add_a = '0;
        add_b = '0;
        add_c = '0;
        case (state_reg)
            ST_IDLE:
            begin
                add_a = i_reg;
                add_c = rc4_pkg::BYTE_W'(1);
            end
            ST_INIT, ST_SWAP:
            begin
                add_a = n_reg;
                add_c = rc4_pkg::BYTE_W'(1);
            end
            ST_MIX:
            begin
                add_a = j_reg;
                add_b = mem_rdata;
                add_c = key_byte;
            end
            ST_PJ:
            begin
                add_a = j_reg;
                add_b = mem_rdata;
            end
            ST_PWR:
            begin
                add_a = si_reg;
                add_b = mem_rdata;
            end
            default:
            begin
                add_a = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        kidx_next     = kidx_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        keyed_next    = keyed_reg;
        si_next       = si_reg;
        sj_next       = sj_reg;
        t_next        = t_reg;
        byp_next      = byp_reg;
        data_next     = data_reg;
        mem_req.we    = 1'b0;
        mem_req.waddr = '0;
        mem_req.wdata = '0;
        mem_req.raddr = '0;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                mem_req.raddr = sum;
                if (in_valid)
                begin
                    data_next = in_data;
                    if (in_start || !keyed_reg)
                    begin
                        n_next     = '0;
                        state_next = ST_INIT;
                    end
                    else
                    begin
                        i_next     = sum;
                        state_next = ST_PJ;
                    end
                end
            end
            ST_INIT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = n_reg;
                mem_req.wdata = n_reg;
                n_next        = sum;
                if (n_reg == LAST_N)
                begin
                    j_next     = '0;
                    kidx_next  = '0;
                    state_next = ST_MIX;
                end
            end
            ST_MIX:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = sum;
                mem_req.wdata = mem_rdata;
                mem_req.raddr = sum;
                j_next        = sum;
                state_next    = ST_SWAP;
            end
            ST_SWAP:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = n_reg;
                mem_req.wdata = mem_rdata;
                if (n_reg == LAST_N)
                begin
                    mem_req.raddr = rc4_pkg::PERM_AW'(1);
                    i_next        = rc4_pkg::BYTE_W'(1);
                    j_next        = '0;
                    keyed_next    = 1'b1;
                    state_next    = ST_PJ;
                end
                else
                begin
                    mem_req.raddr = sum;
                    n_next        = sum;
                    kidx_next     = (kidx_reg == LAST_KEY) ? '0 : kidx_reg + 1'b1;
                    state_next    = ST_MIX;
                end
            end
            ST_PJ:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = sum;
                mem_req.wdata = mem_rdata;
                mem_req.raddr = sum;
                j_next        = sum;
                si_next       = mem_rdata;
                state_next    = ST_PWR;
            end
            ST_PWR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = i_reg;
                mem_req.wdata = mem_rdata;
                mem_req.raddr = sum;
                t_next        = sum;
                sj_next       = mem_rdata;
                byp_next      = (sum == i_reg);
                state_next    = ST_PKS;
            end
            ST_PKS:
            begin
                // hold the read address so the keystream byte stays put
                mem_req.raddr = t_reg;
                res_valid     = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_byte = (byp_reg ? sj_reg : mem_rdata) ^ data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            kidx_reg  <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            keyed_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            kidx_reg  <= kidx_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            keyed_reg <= keyed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        si_reg   <= si_next;
        sj_reg   <= sj_next;
        t_reg    <= t_next;
        byp_reg  <= byp_next;
        data_reg <= data_next;
    end

endmodule

>>> hw/rtl/rc4_stream_cipher.sv
// ----------------------------------------------------------------------------
// RC4 stream cipher
// Byte stream encrypt/decrypt with a 512-bit key register file.
// ----------------------------------------------------------------------------
// Usage:
//   Write the key through cfg_we/cfg_addr/cfg_wdata while the block is idle;
//   register n holds key bytes 8n to 8n+7, lowest byte in the low bits.
//   Send data requests on s_axis; tuser high marks the first byte of a
//   message and reruns key scheduling before that byte. Results leave on
//   m_axis, one byte per request, in order.
// Sequence:
//   A byte of a running message passes through states PJ, PWR and PKS
//   and then the output register on its way to m_axis. The next request
//   is taken only after the result is handed over, since each step uses
//   the single permutation memory. A message start first runs key
//   scheduling: 256 fill steps, then 256 rounds of a mix and a swap step.
// Reset:
//   Clears the key to zero and marks the block unkeyed, so the first byte
//   after reset always runs key scheduling.
// Stall:
//   A waiting result sits in the output register while the next request is
//   accepted; the sequencer holds its result until that register frees up.
// ----------------------------------------------------------------------------
`include "rc4_stream_cipher_defines.svh"

module rc4_stream_cipher
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,   // data_byte
    input  logic                               s_axis_tuser,   // message_start
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [7:0]                         m_axis_tdata,   // out_byte
    input  logic                               cfg_we,
    input  logic [rc4_pkg::KEY_WSEL_W-1:0]     cfg_addr,
    input  logic [rc4_pkg::KEY_WORD_W-1:0]     cfg_wdata
);

    rc4_pkg::key_t              key_reg;
    rc4_pkg::mem_req_t          mem_req;
    logic [rc4_pkg::BYTE_W-1:0] mem_rdata;
    logic                       res_valid;
    logic                       res_ready;
    logic [rc4_pkg::BYTE_W-1:0] res_byte;
    logic                       out_valid_reg, out_valid_next;
    logic [rc4_pkg::BYTE_W-1:0] out_data_reg, out_data_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_we)
        begin
            key_reg[cfg_addr] <= cfg_wdata;
        end
    end

    rc4_perm_ram u_ram
    (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    rc4_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .in_start  (s_axis_tuser),
        .key       (key_reg),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_byte  (res_byte)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_byte;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `RC4_ASSERT_NXT(a_busy_after_request, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `RC4_ASSERT_IMP(a_no_request_with_result, res_valid, !s_axis_tready)
    `RC4_ASSERT_NXT(a_result_held, res_valid && !res_ready, res_valid && $stable(res_byte))

endmodule

>>> tb/sv/tb_rc4_stream_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 stream cipher testbench
// Drives byte requests on s_axis, writes the key through the config port
// between phases and checks every m_axis byte against an RC4 predictor.
// A short directed part covers the first byte after reset, key changes
// inside a running message, back-to-back message starts and the byte
// order in the key words, then runs one message long enough to wrap both
// indices with the output held off long enough to fill the block and
// stall its input. Random phases follow. They mix message lengths and
// apply four flow-control modes.
// ----------------------------------------------------------------------------
module tb_rc4_stream_cipher;

    localparam int HOLD_CYCLES   = 400;
    localparam int PRINT_LIMIT   = 30;
    localparam int PHASE_BYTES   = 90;
    localparam int LONG_MESSAGE  = 300;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } byte_req_t;

    typedef enum int unsigned {
        KEY_ZERO,
        KEY_ONES,
        KEY_COUNT,
        KEY_PARTIAL,
        KEY_RANDOM
    } key_style_t;

    logic                                   clk           = 1'b0;
    logic                                   rst_n         = 1'b0;
    logic                                   s_axis_tvalid = 1'b0;
    logic                                   s_axis_tready;
    logic [7:0]                             s_axis_tdata  = '0;  // data_byte
    logic                                   s_axis_tuser  = 1'b0; // message_start
    logic                                   m_axis_tvalid;
    logic                                   m_axis_tready = 1'b0;
    logic [7:0]                             m_axis_tdata;        // out_byte
    logic                                   cfg_we        = 1'b0;
    logic [rc4_pkg::KEY_WSEL_W-1:0]         cfg_addr      = '0;
    logic [rc4_pkg::KEY_WORD_W-1:0]         cfg_wdata     = '0;

    logic                                   hold_start    = 1'b0;
    int unsigned                            hold_left     = 0;

    byte_req_t                              pending_bytes[$];
    byte_req_t                              next_req;
    logic [7:0]                             expected_bytes[$];

    logic [rc4_pkg::KEY_WORD_W-1:0]         key_reg[rc4_pkg::KEY_WORDS];
    logic [7:0]                             perm_state[rc4_pkg::PERM_DEPTH];
    logic [7:0]                             ks_i;
    logic [7:0]                             ks_j;
    logic                                   keyed;

    int unsigned                            sender_idle_pct    = 0;
    int unsigned                            receiver_stall_pct = 0;
    int unsigned                            bytes_queued       = 0;
    int unsigned                            bytes_accepted     = 0;
    int unsigned                            bytes_checked      = 0;
    int unsigned                            key_schedules      = 0;
    int unsigned                            key_writes         = 0;
    int unsigned                            fail_count         = 0;
    int unsigned                            message_left       = 0;

    rc4_stream_cipher i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic void schedule_key();
        logic [7:0] j;
        logic [7:0] t;
        logic [7:0] kb;
        int         n;
        int         k;
        for (n = 0; n < rc4_pkg::PERM_DEPTH; n++)
        begin
            perm_state[n] = n[7:0];
        end
        j = '0;
        for (n = 0; n < rc4_pkg::PERM_DEPTH; n++)
        begin
            k  = n % rc4_pkg::KEY_BYTES;
            kb = key_reg[k >> 3][8 * (k & 7) +: 8];
            j  = j + perm_state[n] + kb;
            t             = perm_state[n];
            perm_state[n] = perm_state[j];
            perm_state[j] = t;
        end
        ks_i  = '0;
        ks_j  = '0;
        keyed = 1'b1;
        key_schedules++;
    endfunction

    function automatic logic [7:0] crypt_byte(input logic [7:0] data, input logic restart);
        logic [7:0] t;
        logic [7:0] ks_idx;
        if (restart || !keyed)
        begin
            schedule_key();
        end
        ks_i = ks_i + 8'd1;
        ks_j = ks_j + perm_state[ks_i];
        t                = perm_state[ks_i];
        perm_state[ks_i] = perm_state[ks_j];
        perm_state[ks_j] = t;
        ks_idx = perm_state[ks_i] + perm_state[ks_j];
        return perm_state[ks_idx] ^ data;
    endfunction

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_LIMIT)
        begin
            $display("mismatch at %0t ns: %s", $time, msg);
        end
        fail_count++;
    endtask

    // Driver: predict on acceptance, then present the next pending request.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_bytes.push_back(crypt_byte(s_axis_tdata, s_axis_tuser));
                bytes_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    next_req = pending_bytes.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_req.data;
                    s_axis_tuser  <= next_req.start;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Hold-off counter for the long output stall.
    always @(posedge clk)
    begin
        if (hold_start)
        begin
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: check each output byte against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected byte %02h", m_axis_tdata));
                end
                else
                begin
                    if (m_axis_tdata !== expected_bytes[0])
                    begin
                        report_mismatch($sformatf("byte %0d: out_byte %02h, want %02h",
                                                  bytes_checked, m_axis_tdata,
                                                  expected_bytes[0]));
                    end
                    void'(expected_bytes.pop_front());
                    bytes_checked++;
                end
            end
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic queue_request(input logic [7:0] data, input logic start);
        byte_req_t req;
        req.data  = data;
        req.start = start;
        pending_bytes.push_back(req);
        bytes_queued++;
    endtask

    task automatic wait_idle();
        while (bytes_accepted != bytes_queued || expected_bytes.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Call right after a rising edge with the block idle.
    task automatic load_key(input key_style_t style);
        logic [rc4_pkg::KEY_WORD_W-1:0] word;
        int                             n;
        int                             b;
        for (n = 0; n < rc4_pkg::KEY_WORDS; n++)
        begin
            case (style)
                KEY_ZERO:  word = '0;
                KEY_ONES:  word = '1;
                KEY_COUNT:
                begin
                    for (b = 0; b < 8; b++)
                    begin
                        word[8 * b +: 8] = 8'(8 * n + b);
                    end
                end
                default:   word = {$urandom, $urandom};
            endcase
            if (style != KEY_PARTIAL || $urandom_range(1) == 1)
            begin
                cfg_we    <= 1'b1;
                cfg_addr  <= n[rc4_pkg::KEY_WSEL_W-1:0];
                cfg_wdata <= word;
                key_reg[n] = word;
                key_writes++;
                @(posedge clk);
            end
        end
        cfg_we <= 1'b0;
    endtask

    task automatic queue_random_bytes(input int count);
        int          n;
        int unsigned r;
        logic        start;
        for (n = 0; n < count; n++)
        begin
            if (message_left == 0)
            begin
                r = $urandom_range(99);
                if (r < 4)
                begin
                    message_left = $urandom_range(400, 257);
                end
                else if (r < 30)
                begin
                    message_left = $urandom_range(4, 1);
                end
                else
                begin
                    message_left = $urandom_range(30, 5);
                end
                start = 1'b1;
            end
            else
            begin
                start = ($urandom_range(99) < 3);
            end
            message_left--;
            queue_request(8'($urandom_range(255)), start);
        end
    endtask

    initial
    begin
        int          p;
        int          n;
        int unsigned base;

        for (n = 0; n < rc4_pkg::KEY_WORDS; n++)
        begin
            key_reg[n] = '0;
        end
        keyed = 1'b0;
        ks_i  = '0;
        ks_j  = '0;
        for (n = 0; n < rc4_pkg::PERM_DEPTH; n++)
        begin
            perm_state[n] = '0;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First byte after reset keys with the zero key, start flag low.
        queue_request(8'h00, 1'b0);
        queue_request(8'hFF, 1'b0);
        queue_request(8'h5A, 1'b0);
        queue_request(8'hA5, 1'b1);
        queue_request(8'h00, 1'b0);
        wait_idle();

        // New key mid-message: the running stream must not change.
        load_key(KEY_ONES);
        queue_request(8'h3C, 1'b0);
        queue_request(8'hFF, 1'b1);
        queue_request(8'h81, 1'b0);
        queue_request(8'h00, 1'b1);
        queue_request(8'h7E, 1'b1);
        wait_idle();

        // Counting key pins down the byte order inside each word.
        load_key(KEY_COUNT);
        queue_request(8'h00, 1'b1);
        queue_request(8'hFF, 1'b0);
        queue_request(8'h01, 1'b0);
        queue_request(8'h80, 1'b0);
        queue_request(8'h10, 1'b1);
        wait_idle();

        load_key(KEY_ZERO);
        queue_request(8'hC3, 1'b1);
        queue_request(8'h00, 1'b0);
        wait_idle();

        load_key(KEY_RANDOM);
        queue_request(8'hFF, 1'b1);
        queue_request(8'h42, 1'b0);
        queue_request(8'hBD, 1'b0);
        wait_idle();

        // Long message with the output held off: fill the block, wrap both indices.
        load_key(KEY_RANDOM);
        base = bytes_accepted;
        for (n = 0; n < LONG_MESSAGE; n++)
        begin
            queue_request(8'($urandom_range(255)), n == 0);
        end
        while (bytes_accepted < base + 3)
        begin
            @(posedge clk);
        end
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        wait_idle();

        for (p = 0; p < 8; p++)
        begin
            case (p % 4)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 73;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 73;
                end
                default:
                begin
                    sender_idle_pct    = 21;
                    receiver_stall_pct = 21;
                end
            endcase
            case ($urandom_range(9))
                0:       load_key(KEY_ZERO);
                1:       load_key(KEY_ONES);
                2, 3, 4: load_key(KEY_PARTIAL);
                default: load_key(KEY_RANDOM);
            endcase
            queue_random_bytes(PHASE_BYTES);
            wait_idle();
        end

        // Catch stray bytes after the last expected one.
        repeat (50) @(posedge clk);

        $display("Checked %0d bytes over %0d key schedules with %0d key word writes,",
                 bytes_checked, key_schedules, key_writes);
        $display("under four flow-control modes and one %0d-cycle output hold-off.",
                 HOLD_CYCLES);
        if (fail_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
